// ===== rtl/core/ufg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ufg_pkg
// Shared widths, register indexes and result packing for the utilization
// floor governor.
// ----------------------------------------------------------------------------
package ufg_pkg;

    // field widths
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned LEVEL_W     = 4;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned RESULT_W    = 8;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPIKE_THRESHOLD     = 3'd0,
        CFG_RAISE_THRESHOLD     = 3'd1,
        CFG_DROP_THRESHOLD      = 3'd2,
        CFG_BURST_HOLD_TICKS    = 3'd3,
        CFG_COOLDOWN_TICKS      = 3'd4,
        CFG_RAISE_CONFIRM_TICKS = 3'd5,
        CFG_DROP_CONFIRM_TICKS  = 3'd6,
        CFG_NORMAL_MAX_LEVEL    = 3'd7
    } cfg_reg_t;

    // result item, lowest bit first: floor_changed, floor_level, zero pad
    typedef struct packed {
        logic [RESULT_W-LEVEL_W-2:0] pad;
        logic [LEVEL_W-1:0]          floor_level;
        logic                        floor_changed;
    } result_t;

endpackage : ufg_pkg
`default_nettype wire

// ===== rtl/core/utilization_dvfs_floor_governor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utilization_dvfs_floor_governor
// Dual exponential average DVFS floor governor with spike bursts.
// ----------------------------------------------------------------------------
// One utilization sample per transaction in, one floor result per transaction
// out. The block takes a sample in every cycle in which it is ready: the
// average, burst and trend update for a sample is done in the cycle it is
// accepted and lands in the result register, so the rate is one sample per
// cycle while results are taken, and a result is valid in the cycle after its
// sample. The input side stays ready while the result register is empty or
// its result is being taken in the same cycle. Configuration writes are
// always taken and should only be made while no result is pending.
// ----------------------------------------------------------------------------
module utilization_dvfs_floor_governor #(
    parameter int unsigned LEVEL_COUNT = 16,
    parameter int unsigned BURST_STEPS = 2,
    parameter int unsigned FAST_SHIFT  = 1,
    parameter int unsigned SLOW_SHIFT  = 3
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // sample stream
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [ufg_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [15:0] util_sample
    // result stream
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [ufg_pkg::RESULT_W-1:0]      m_axis_tdata,   // [0] floor_changed,
                                                              // [4:1] floor_level
    // configuration writes
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [ufg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire  [ufg_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned SW = ufg_pkg::SAMPLE_W;
    localparam int unsigned LW = ufg_pkg::LEVEL_W;

    // highest level, clipped to the floor field
    localparam int unsigned TOP_INT = (LEVEL_COUNT - 1 > 15) ? 15 : LEVEL_COUNT - 1;
    localparam logic [LW:0] TOP     = (LW+1)'(TOP_INT);
    localparam logic [LW+1:0] BURST_ADD = (LW+2)'(BURST_STEPS);

    // configuration registers
    logic [SW-1:0] spike_threshold_reg;
    logic [SW-1:0] raise_threshold_reg;
    logic [SW-1:0] drop_threshold_reg;
    logic [SW-1:0] burst_hold_ticks_reg;
    logic [SW-1:0] cooldown_ticks_reg;
    logic [SW-1:0] raise_confirm_ticks_reg;
    logic [SW-1:0] drop_confirm_ticks_reg;
    logic [LW-1:0] normal_max_level_reg;

    // governor state
    logic [SW-1:0] fast_average_reg, fast_average_next;
    logic [SW-1:0] slow_average_reg, slow_average_next;
    logic [LW-1:0] floor_index_reg,  floor_index_next;
    logic          burst_active_reg, burst_active_next;
    logic [SW-1:0] burst_left_reg,   burst_left_next;
    logic [SW-1:0] cooldown_left_reg, cooldown_left_next;
    logic [SW-1:0] raise_count_reg,  raise_count_next;
    logic [SW-1:0] drop_count_reg,   drop_count_next;

    // result register
    logic               result_valid_reg;
    ufg_pkg::result_t   result_reg, result_next;

    logic in_accept;
    logic changed;

    // datapath intermediates
    logic signed [SW:0] fast_diff, slow_diff;
    logic signed [SW:0] trend, deviation;
    logic [SW-1:0]      raise_count_inc, drop_count_inc;
    logic [LW:0]        nmax;
    logic [LW+1:0]      burst_floor;
    logic               spike, raise_cond, drop_cond;

    assign s_axis_tready = !result_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = result_valid_reg;
    assign m_axis_tdata  = result_reg;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spike_threshold_reg     <= 16'd16384;
            raise_threshold_reg     <= 16'd45875;
            drop_threshold_reg      <= 16'd19661;
            burst_hold_ticks_reg    <= 16'd10;
            cooldown_ticks_reg      <= 16'd20;
            raise_confirm_ticks_reg <= 16'd3;
            drop_confirm_ticks_reg  <= 16'd5;
            normal_max_level_reg    <= 4'd12;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ufg_pkg::cfg_reg_t'(cfg_index))
                ufg_pkg::CFG_SPIKE_THRESHOLD:     spike_threshold_reg     <= cfg_data;
                ufg_pkg::CFG_RAISE_THRESHOLD:     raise_threshold_reg     <= cfg_data;
                ufg_pkg::CFG_DROP_THRESHOLD:      drop_threshold_reg      <= cfg_data;
                ufg_pkg::CFG_BURST_HOLD_TICKS:    burst_hold_ticks_reg    <= cfg_data;
                ufg_pkg::CFG_COOLDOWN_TICKS:      cooldown_ticks_reg      <= cfg_data;
                ufg_pkg::CFG_RAISE_CONFIRM_TICKS: raise_confirm_ticks_reg <= cfg_data;
                ufg_pkg::CFG_DROP_CONFIRM_TICKS:  drop_confirm_ticks_reg  <= cfg_data;
                ufg_pkg::CFG_NORMAL_MAX_LEVEL:    normal_max_level_reg    <= cfg_data[LW-1:0];
            endcase
        end
    end

    // average update, floor-rounded arithmetic shift of the signed difference
    always_comb
    begin
        fast_diff = $signed({1'b0, s_axis_tdata}) - $signed({1'b0, fast_average_reg});
        slow_diff = $signed({1'b0, s_axis_tdata}) - $signed({1'b0, slow_average_reg});
        fast_average_next = fast_average_reg + SW'(fast_diff >>> FAST_SHIFT);
        slow_average_next = slow_average_reg + SW'(slow_diff >>> SLOW_SHIFT);
        trend     = $signed({1'b0, fast_average_next}) - $signed({1'b0, slow_average_next});
        deviation = $signed({1'b0, s_axis_tdata}) - $signed({1'b0, fast_average_next});
    end

    // burst and trend decisions
    always_comb
    begin
        nmax            = ({1'b0, normal_max_level_reg} > TOP) ? TOP
                                                               : {1'b0, normal_max_level_reg};
        burst_floor     = {2'b00, floor_index_reg} + BURST_ADD;
        spike           = !burst_active_reg && (cooldown_left_reg == '0)
                          && (deviation >= $signed({1'b0, spike_threshold_reg}));
        raise_cond      = (fast_average_next > raise_threshold_reg) && (trend > 0);
        drop_cond       = (fast_average_next < drop_threshold_reg) && (trend < 0);
        raise_count_inc = raise_count_reg + 1'b1;
        drop_count_inc  = drop_count_reg + 1'b1;

        burst_active_next  = burst_active_reg;
        burst_left_next    = burst_left_reg;
        cooldown_left_next = cooldown_left_reg;
        raise_count_next   = raise_count_reg;
        drop_count_next    = drop_count_reg;
        floor_index_next   = floor_index_reg;
        changed            = 1'b0;

        priority if (spike)
        begin
            // spike: lift the floor and start the hold
            burst_active_next = 1'b1;
            burst_left_next   = burst_hold_ticks_reg;
            raise_count_next  = '0;
            drop_count_next   = '0;
            floor_index_next  = (burst_floor > {1'b0, TOP}) ? TOP[LW-1:0]
                                                            : burst_floor[LW-1:0];
            changed           = (floor_index_next != floor_index_reg);
        end
        else if (burst_active_reg)
        begin
            // hold countdown, last tick loads the cooldown
            if (burst_left_reg <= 16'd1)
            begin
                burst_left_next    = '0;
                burst_active_next  = 1'b0;
                cooldown_left_next = cooldown_ticks_reg;
            end
            else
            begin
                burst_left_next = burst_left_reg - 1'b1;
            end
        end
        else
        begin
            if (cooldown_left_reg != '0)
            begin
                cooldown_left_next = cooldown_left_reg - 1'b1;
            end
            priority if (raise_cond)
            begin
                drop_count_next  = '0;
                raise_count_next = raise_count_inc;
                if (raise_count_inc >= raise_confirm_ticks_reg)
                begin
                    raise_count_next = '0;
                    if ({1'b0, floor_index_reg} + 1'b1 <= nmax)
                    begin
                        floor_index_next = floor_index_reg + 1'b1;
                        changed          = 1'b1;
                    end
                end
            end
            else if (drop_cond)
            begin
                raise_count_next = '0;
                drop_count_next  = drop_count_inc;
                if (drop_count_inc >= drop_confirm_ticks_reg)
                begin
                    drop_count_next = '0;
                    if (floor_index_reg != '0)
                    begin
                        floor_index_next = floor_index_reg - 1'b1;
                        changed          = 1'b1;
                    end
                end
            end
            else
            begin
                raise_count_next = '0;
                drop_count_next  = '0;
            end
        end

        result_next               = '0;
        result_next.floor_changed = changed;
        result_next.floor_level   = floor_index_next;
    end

    // state update on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_average_reg  <= '0;
            slow_average_reg  <= '0;
            floor_index_reg   <= '0;
            burst_active_reg  <= 1'b0;
            burst_left_reg    <= '0;
            cooldown_left_reg <= '0;
            raise_count_reg   <= '0;
            drop_count_reg    <= '0;
        end
        else if (in_accept)
        begin
            fast_average_reg  <= fast_average_next;
            slow_average_reg  <= slow_average_next;
            floor_index_reg   <= floor_index_next;
            burst_active_reg  <= burst_active_next;
            burst_left_reg    <= burst_left_next;
            cooldown_left_reg <= cooldown_left_next;
            raise_count_reg   <= raise_count_next;
            drop_count_reg    <= drop_count_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule : utilization_dvfs_floor_governor
`default_nettype wire

// ===== rtl/core/ufg_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ufg_checker
// Port-level checks for the utilization floor governor, bound to the top.
// ----------------------------------------------------------------------------
module ufg_checker (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [ufg_pkg::RESULT_W-1:0]     m_axis_tdata
);

    // a stalled result holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // every accepted sample produces a result in the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted sample gave no result");

    // a taken result with no new sample leaves the output empty
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready))
        |=> !m_axis_tvalid)
        else $error("result repeated or invented");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule : ufg_checker

bind utilization_dvfs_floor_governor ufg_checker u_ufg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== test/utilization_dvfs_floor_governor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utilization_dvfs_floor_governor_tb
// Self-checking bench for the dual-average utilization floor governor.
// ----------------------------------------------------------------------------
// Samples are pushed through the sample stream under several register
// settings. A scoreboard keeps its own copy of the averages, burst, cooldown
// and trend counters, predicts the floor result of every accepted sample and
// compares each result transaction field by field in order. Both stream sides
// idle at random, and the result side holds off for a long stretch once so
// that the block backs up its input.
// ----------------------------------------------------------------------------
module utilization_dvfs_floor_governor_tb;

    localparam int unsigned LEVEL_COUNT = 16;
    localparam int unsigned BURST_STEPS = 2;
    localparam int unsigned FAST_SHIFT  = 1;
    localparam int unsigned SLOW_SHIFT  = 3;
    localparam int TOP_LEVEL = (LEVEL_COUNT - 1 > 15) ? 15 : LEVEL_COUNT - 1;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_SAMPLES   = 200;
    localparam int PHASE_COUNT     = 7;
    localparam int HOLD_OFF_CYCLES = 300;

    // one full register setting
    typedef struct {
        bit [15:0] spike;
        bit [15:0] raise;
        bit [15:0] drop;
        bit [15:0] hold;
        bit [15:0] cool;
        bit [15:0] raise_need;
        bit [15:0] drop_need;
        bit [3:0]  nmax;
    } governor_setting_t;

    // shapes of utilization segments in the random part
    typedef enum int {
        SEG_HIGH,
        SEG_LOW,
        SEG_RISE,
        SEG_FALL,
        SEG_BURSTY,
        SEG_NOISE
    } load_shape_t;

    // ------------------------------------------------------------------------
    // floor predictor and result store
    // ------------------------------------------------------------------------
    class floor_scoreboard;
        bit [15:0] spike_thr, raise_thr, drop_thr;
        bit [15:0] hold_ticks, cool_ticks, raise_need, drop_need;
        bit [3:0]  nmax_level;

        bit [15:0] fast_avg, slow_avg;
        bit [3:0]  floor_idx;
        bit        burst_on;
        bit [15:0] burst_rem, cool_rem, raise_cnt, drop_cnt;

        ufg_pkg::result_t expected_results[$];
        int        errors;
        int        samples;
        int        checked;
        int        changes;

        function new();
            spike_thr  = 16'd16384;
            raise_thr  = 16'd45875;
            drop_thr   = 16'd19661;
            hold_ticks = 16'd10;
            cool_ticks = 16'd20;
            raise_need = 16'd3;
            drop_need  = 16'd5;
            nmax_level = 4'd12;
            fast_avg   = '0;
            slow_avg   = '0;
            floor_idx  = '0;
            burst_on   = 1'b0;
            burst_rem  = '0;
            cool_rem   = '0;
            raise_cnt  = '0;
            drop_cnt   = '0;
            errors     = 0;
            samples    = 0;
            checked    = 0;
            changes    = 0;
        endfunction

        function void set_reg(ufg_pkg::cfg_reg_t idx, bit [15:0] val);
            case (idx)
                ufg_pkg::CFG_SPIKE_THRESHOLD:     spike_thr  = val;
                ufg_pkg::CFG_RAISE_THRESHOLD:     raise_thr  = val;
                ufg_pkg::CFG_DROP_THRESHOLD:      drop_thr   = val;
                ufg_pkg::CFG_BURST_HOLD_TICKS:    hold_ticks = val;
                ufg_pkg::CFG_COOLDOWN_TICKS:      cool_ticks = val;
                ufg_pkg::CFG_RAISE_CONFIRM_TICKS: raise_need = val;
                ufg_pkg::CFG_DROP_CONFIRM_TICKS:  drop_need  = val;
                ufg_pkg::CFG_NORMAL_MAX_LEVEL:    nmax_level = val[3:0];
                default: ;
            endcase
        endfunction

        // avg += (x - avg) >>> shift, arithmetic shift of the signed difference
        function bit [15:0] ema(bit [15:0] avg, bit [15:0] x, int unsigned sh);
            int diff;
            diff = int'(x) - int'(avg);
            return 16'(int'(avg) + (diff >>> sh));
        endfunction

        function void note_sample(bit [15:0] util);
            int      trend;
            int      dev;
            int      nmax;
            int      lifted;
            bit      changed;
            bit [3:0] prev;
            ufg_pkg::result_t r;

            nmax    = (int'(nmax_level) > TOP_LEVEL) ? TOP_LEVEL : int'(nmax_level);
            prev    = floor_idx;
            changed = 1'b0;
            samples++;

            fast_avg = ema(fast_avg, util, FAST_SHIFT);
            slow_avg = ema(slow_avg, util, SLOW_SHIFT);
            trend    = int'(fast_avg) - int'(slow_avg);
            dev      = int'(util) - int'(fast_avg);

            if (!burst_on && cool_rem == 0 && dev >= int'(spike_thr))
            begin
                // spike starts a burst and clears both trend counts
                lifted    = int'(floor_idx) + int'(BURST_STEPS);
                burst_on  = 1'b1;
                burst_rem = hold_ticks;
                raise_cnt = '0;
                drop_cnt  = '0;
                floor_idx = 4'((lifted > TOP_LEVEL) ? TOP_LEVEL : lifted);
                changed   = (floor_idx != prev);
            end
            else if (burst_on)
            begin
                // burst countdown, last tick reloads the cooldown
                if (burst_rem <= 16'd1)
                begin
                    burst_rem = '0;
                    burst_on  = 1'b0;
                    cool_rem  = cool_ticks;
                end
                else
                begin
                    burst_rem--;
                end
            end
            else
            begin
                if (cool_rem > 0)
                    cool_rem--;
                if (fast_avg > raise_thr && trend > 0)
                begin
                    drop_cnt = '0;
                    raise_cnt++;
                    if (raise_cnt >= raise_need)
                    begin
                        raise_cnt = '0;
                        if (int'(floor_idx) + 1 <= nmax)
                        begin
                            floor_idx++;
                            changed = 1'b1;
                        end
                    end
                end
                else if (fast_avg < drop_thr && trend < 0)
                begin
                    raise_cnt = '0;
                    drop_cnt++;
                    if (drop_cnt >= drop_need)
                    begin
                        drop_cnt = '0;
                        if (floor_idx > 0)
                        begin
                            floor_idx--;
                            changed = 1'b1;
                        end
                    end
                end
                else
                begin
                    raise_cnt = '0;
                    drop_cnt  = '0;
                end
            end

            r               = '0;
            r.floor_changed = changed;
            r.floor_level   = floor_idx;
            expected_results.push_back(r);
        endfunction

        function void check_result(ufg_pkg::result_t got);
            ufg_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                $error("floor result %0h arrived with no sample pending", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.floor_changed)
                changes++;
            if (got.floor_changed !== want.floor_changed)
            begin
                $error("floor_changed: expected %0d, actual %0d",
                       want.floor_changed, got.floor_changed);
                errors++;
            end
            if (got.floor_level !== want.floor_level)
            begin
                $error("floor_level: expected %0d, actual %0d",
                       want.floor_level, got.floor_level);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_valid   = 1'b0;
    logic [15:0] s_data    = '0;
    logic        m_ready   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_idx   = '0;
    logic [15:0] cfg_wdata = '0;

    logic                         s_axis_tready;
    logic                         m_axis_tvalid;
    logic [ufg_pkg::RESULT_W-1:0] m_axis_tdata;
    logic                         cfg_ready;

    floor_scoreboard sb;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_request  = 0;
    int cycle_count   = 0;
    int settings_used = 0;

    // segment generator state
    load_shape_t seg_kind = SEG_NOISE;
    int          seg_left = 0;
    bit [15:0]   ramp_val = '0;

    utilization_dvfs_floor_governor #(
        .LEVEL_COUNT (LEVEL_COUNT),
        .BURST_STEPS (BURST_STEPS),
        .FAST_SHIFT  (FAST_SHIFT),
        .SLOW_SHIFT  (SLOW_SHIFT)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),        // [15:0] util_sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),  // [0] floor_changed, [4:1] floor_level
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_idx),
        .cfg_data      (cfg_wdata)
    );

    // clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side ready, with random idling and the long hold-off
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_ready <= 1'b0;
            end
            else
            begin
                m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // result transaction check
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_ready)
            sb.check_result(ufg_pkg::result_t'(m_axis_tdata));
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // offer one sample, called and returning at a falling edge
    task automatic offer_sample(input bit [15:0] util);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= util;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_sample(util);
        @(negedge clk);
    endtask

    task automatic write_reg(input ufg_pkg::cfg_reg_t idx, input bit [15:0] val);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic program_setting(input governor_setting_t st);
        write_reg(ufg_pkg::CFG_SPIKE_THRESHOLD,     st.spike);
        write_reg(ufg_pkg::CFG_RAISE_THRESHOLD,     st.raise);
        write_reg(ufg_pkg::CFG_DROP_THRESHOLD,      st.drop);
        write_reg(ufg_pkg::CFG_BURST_HOLD_TICKS,    st.hold);
        write_reg(ufg_pkg::CFG_COOLDOWN_TICKS,      st.cool);
        write_reg(ufg_pkg::CFG_RAISE_CONFIRM_TICKS, st.raise_need);
        write_reg(ufg_pkg::CFG_DROP_CONFIRM_TICKS,  st.drop_need);
        write_reg(ufg_pkg::CFG_NORMAL_MAX_LEVEL,    16'(st.nmax));
        cfg_valid <= 1'b0;
        settings_used++;
        @(negedge clk);
    endtask

    // stop offering and wait until every predicted result has arrived
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    function automatic governor_setting_t random_setting();
        governor_setting_t st;
        st.spike      = 16'($urandom_range(0, 40000));
        st.raise      = 16'($urandom_range(20000, 60000));
        st.drop       = 16'($urandom_range(5000, 40000));
        st.hold       = 16'($urandom_range(0, 20));
        st.cool       = 16'($urandom_range(0, 30));
        st.raise_need = 16'($urandom_range(0, 6));
        st.drop_need  = 16'($urandom_range(0, 6));
        st.nmax       = 4'($urandom_range(0, 15));
        return st;
    endfunction

    // load made of segments: sustained, ramps, isolated spikes, some noise
    function automatic bit [15:0] next_util();
        bit [15:0] v;
        if (seg_left == 0)
        begin
            seg_kind = load_shape_t'($urandom_range(0, 5));
            seg_left = $urandom_range(3, 40);
            ramp_val = 16'($urandom);
        end
        seg_left--;
        case (seg_kind)
            SEG_HIGH:   v = 16'($urandom_range(50000, 65535));
            SEG_LOW:    v = 16'($urandom_range(0, 12000));
            SEG_RISE:
            begin
                ramp_val = ramp_val + 16'd1500;
                v = ramp_val;
            end
            SEG_FALL:
            begin
                ramp_val = ramp_val - 16'd1500;
                v = ramp_val;
            end
            SEG_BURSTY: v = (seg_left % 8 == 0) ? 16'hFFFF : 16'($urandom_range(0, 8000));
            default:    v = 16'($urandom);
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        governor_setting_t st;
        bit [15:0] directed_samples[$];
        int ph;

        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero hold, short cooldown, zero raise confirm, low normal max
        src_idle_pct  = 9;
        sink_idle_pct = 87;
        st.spike      = 16'd16384;
        st.raise      = 16'd45875;
        st.drop       = 16'd19661;
        st.hold       = 16'd0;
        st.cool       = 16'd2;
        st.raise_need = 16'd0;
        st.drop_need  = 16'd1;
        st.nmax       = 4'd3;
        program_setting(st);
        directed_samples = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                             16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             16'hFFFF, 16'hFFFF, 16'h8000, 16'h0001, 16'hFFFE,
                             16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF, 16'h0000};
        foreach (directed_samples[i])
            offer_sample(directed_samples[i]);
        drain();

        // random phases over several settings, power-on values and extremes first
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:
                begin
                    // power-on values
                    st.spike      = 16'd16384;
                    st.raise      = 16'd45875;
                    st.drop       = 16'd19661;
                    st.hold       = 16'd10;
                    st.cool       = 16'd20;
                    st.raise_need = 16'd3;
                    st.drop_need  = 16'd5;
                    st.nmax       = 4'd12;
                end
                1:
                begin
                    // everything triggers at once
                    st.spike      = 16'd0;
                    st.raise      = 16'd0;
                    st.drop       = 16'hFFFF;
                    st.hold       = 16'd0;
                    st.cool       = 16'd0;
                    st.raise_need = 16'd1;
                    st.drop_need  = 16'd1;
                    st.nmax       = 4'd15;
                end
                2:
                begin
                    // nothing can trigger
                    st.spike      = 16'hFFFF;
                    st.raise      = 16'hFFFF;
                    st.drop       = 16'd0;
                    st.hold       = 16'hFFFF;
                    st.cool       = 16'hFFFF;
                    st.raise_need = 16'hFFFF;
                    st.drop_need  = 16'hFFFF;
                    st.nmax       = 4'd0;
                end
                default: st = random_setting();
            endcase

            if (ph < 2)
            begin
                src_idle_pct  = 9;
                sink_idle_pct = 87;
            end
            else if (ph < 4)
            begin
                src_idle_pct  = 87;
                sink_idle_pct = 9;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end

            program_setting(st);
            // result side stalls for a long stretch while samples keep coming
            if (ph == 5)
                hold_request = HOLD_OFF_CYCLES;
            repeat (PHASE_SAMPLES)
                offer_sample(next_util());
            drain();
        end

        $display("covered %0d samples under %0d register settings, %0d floor changes seen",
                 sb.samples, settings_used, sb.changes);
        $display("idle mixes on both sides plus a %0d-cycle result stall, %0d mismatches",
                 HOLD_OFF_CYCLES, sb.errors);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
